### hdl/key_matrix_event_encoder_macros.svh
// Assertion macros for the key matrix event encoder
`ifndef KEY_MATRIX_EVENT_ENCODER_MACROS_SVH
`define KEY_MATRIX_EVENT_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define KME_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KME_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KME_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define KME_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hdl/kme_pkg.sv
// Types, constants and key tables shared by the key matrix event encoder
package kme_pkg;

  localparam int COLUMNS = 5;
  localparam int ROWS    = 7;
  localparam int CODE_W  = 7;
  localparam int COL_W   = 3;
  localparam int ROW_W   = 3;
  localparam int LIMIT_W = 6;
  localparam int CNT_W   = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(COLUMNS * ROWS);

  localparam logic CMD_APPLY  = 1'b0;
  localparam logic CMD_RESYNC = 1'b1;

  localparam logic [CODE_W-1:0] CHAR_LC_A   = 7'h61;
  localparam logic [CODE_W-1:0] CHAR_LC_Z   = 7'h7a;
  localparam logic [CODE_W-1:0] CASE_OFFSET = 7'h61 - 7'h41;

  localparam logic [CODE_W-1:0] BASE_MAP [COLUMNS][ROWS] = '{
    '{7'h71, 7'h77, 7'h00, 7'h61, 7'h00, 7'h20, 7'h00},
    '{7'h65, 7'h73, 7'h64, 7'h70, 7'h78, 7'h7a, 7'h00},
    '{7'h72, 7'h67, 7'h74, 7'h00, 7'h76, 7'h63, 7'h66},
    '{7'h75, 7'h68, 7'h79, 7'h0d, 7'h62, 7'h6e, 7'h6a},
    '{7'h6f, 7'h6c, 7'h69, 7'h08, 7'h24, 7'h6d, 7'h6b}
  };

  localparam logic [CODE_W-1:0] SYMBOL_MAP [COLUMNS][ROWS] = '{
    '{7'h23, 7'h31, 7'h00, 7'h2a, 7'h00, 7'h00, 7'h30},
    '{7'h32, 7'h34, 7'h35, 7'h40, 7'h38, 7'h37, 7'h00},
    '{7'h33, 7'h2f, 7'h28, 7'h00, 7'h3f, 7'h39, 7'h36},
    '{7'h5f, 7'h3a, 7'h29, 7'h00, 7'h21, 7'h2c, 7'h3b},
    '{7'h2b, 7'h22, 7'h2d, 7'h00, 7'h00, 7'h2e, 7'h27}
  };

  typedef struct packed {
    logic       cmd;
    logic [7:0] column_0;
    logic [7:0] column_1;
    logic [7:0] column_2;
    logic [7:0] column_3;
    logic [7:0] column_4;
  } snap_t;

  typedef struct packed {
    logic [CODE_W-1:0] key_code;
    logic [COL_W-1:0]  column_index;
    logic [ROW_W-1:0]  row_index;
    logic              pressed;
    logic              symbol_held;
    logic              alt_held;
    logic              shift_held;
    logic              mod_key;
    logic              last;
  } evt_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic apply;
    logic sym;
    logic shift;
  } lane_ctl_t;

  typedef struct packed {
    logic              changed;
    logic              down;
    logic [CODE_W-1:0] code;
  } lane_hit_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] total;
    logic               sym;
    logic               alt;
    logic               shift;
  } scan_ctx_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } scan_state_t;

  function automatic logic [CODE_W-1:0] key_lookup(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row,
                                                   input logic sym,
                                                   input logic shift);
    logic [CODE_W-1:0] code;
    code = sym ? SYMBOL_MAP[col][row] : BASE_MAP[col][row];
    if (shift && code >= CHAR_LC_A && code <= CHAR_LC_Z) begin
      code = code - CASE_OFFSET;
    end
    return code;
  endfunction

  function automatic logic mod_position(input logic [COL_W-1:0] col,
                                        input logic [ROW_W-1:0] row);
    return (col == 3'd0 && (row == 3'd2 || row == 3'd4)) ||
           (col == 3'd1 && row == 3'd6) ||
           (col == 3'd2 && row == 3'd3);
  endfunction

endpackage

### hdl/kme_lane.sv
// One matrix column: previous rows, latched codes and captured changes
module kme_lane #(
  parameter int COL = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  kme_pkg::lane_ctl_t         ctl,
  input  logic [kme_pkg::ROWS-1:0]   rows,
  input  logic [kme_pkg::ROW_W-1:0]  sel_row,
  output kme_pkg::lane_hit_t         hit,
  output logic [kme_pkg::CNT_W-1:0]  change_count
);
  import kme_pkg::*;

  logic [ROWS-1:0]   prev;
  logic [CODE_W-1:0] latched [ROWS];
  logic [ROWS-1:0]   ev_changed;
  logic [ROWS-1:0]   ev_down;
  logic [CODE_W-1:0] ev_code [ROWS];

  logic [ROWS-1:0]   changed;
  logic [CODE_W-1:0] press_code [ROWS];

  always_comb begin
    changed = prev ^ rows;
    for (int r = 0; r < ROWS; r++) begin
      press_code[r] = key_lookup(COL_W'(COL), ROW_W'(r), ctl.sym, ctl.shift);
    end
  end

  assign change_count = CNT_W'($countones(changed));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      prev <= '0;
      for (int r = 0; r < ROWS; r++) begin
        latched[r] <= '0;
      end
    end else if (ctl.load) begin
      prev <= rows;
      for (int r = 0; r < ROWS; r++) begin
        latched[r] <= rows[r] ? press_code[r] : '0;
      end
    end else if (ctl.apply) begin
      prev <= rows;
      for (int r = 0; r < ROWS; r++) begin
        if (changed[r]) begin
          latched[r] <= rows[r] ? press_code[r] : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      ev_changed <= changed;
      ev_down    <= rows;
      for (int r = 0; r < ROWS; r++) begin
        ev_code[r] <= rows[r] ? press_code[r] : latched[r];
      end
    end
  end

  always_comb begin
    hit.changed = ev_changed[sel_row];
    hit.down    = ev_down[sel_row];
    hit.code    = ev_code[sel_row];
  end

endmodule

### hdl/kme_merge.sv
// Walks the lanes in column-major order and issues event beats
module kme_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  kme_pkg::scan_ctx_t        ctx,
  input  kme_pkg::lane_hit_t        hits [kme_pkg::COLUMNS],
  output logic [kme_pkg::ROW_W-1:0] sel_row,
  output logic                      busy,
  output kme_pkg::evt_t             evt,
  output logic                      evt_valid,
  input  logic                      evt_stall
);
  import kme_pkg::*;

  scan_state_t        state, state_next;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [LIMIT_W-1:0] sent;
  scan_ctx_t          ctx_q;

  lane_hit_t hit;
  logic      slot_free;
  logic      step;
  logic      emit;
  logic      at_end;
  logic      row_end;

  always_comb begin
    hit       = hits[col];
    slot_free = !evt_valid || !evt_stall;
    row_end   = row == ROW_W'(ROWS - 1);
    at_end    = row_end && col == COL_W'(COLUMNS - 1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_SCAN;
      ST_SCAN: if (step && at_end) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    step = 1'b0;
    unique case (state)
      ST_IDLE: busy = 1'b0;
      ST_SCAN: begin
        busy = 1'b1;
        step = slot_free;
      end
      default: busy = 1'b0;
    endcase
    emit = step && hit.changed && (sent < ctx_q.total);
  end

  assign sel_row = row;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      col   <= '0;
      row   <= '0;
      sent  <= '0;
      ctx_q <= ctx;
    end else if (step) begin
      row <= row_end ? '0 : row + ROW_W'(1);
      if (row_end) begin
        col <= col + COL_W'(1);
      end
      if (emit) begin
        sent <= sent + LIMIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else begin
      evt_valid <= emit || (evt_valid && evt_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      evt.key_code     <= hit.code;
      evt.column_index <= col;
      evt.row_index    <= row;
      evt.pressed      <= hit.down;
      evt.symbol_held  <= ctx_q.sym;
      evt.alt_held     <= ctx_q.alt;
      evt.shift_held   <= ctx_q.shift;
      evt.mod_key      <= mod_position(col, row);
      evt.last         <= (sent + LIMIT_W'(1)) == ctx_q.total;
    end
  end

endmodule

### hdl/key_matrix_event_encoder.sv
// Key matrix event encoder top level: lanes per column, scan merger, limit register
// A snapshot beat is taken when snap_valid is high and the block is not busy; a
// resync or the first snapshot after it only updates state and the block is ready
// again on the next cycle. Any other snapshot is compared in all five column lanes
// at once, then the merger visits the 35 key positions one per cycle while no
// event beat waits stalled at the output; snap_stall stays high during the scan.
// The final event beat may still wait at the output while the next snapshot is
// taken. event_limit is written through cfg_write/cfg_data; the user must write
// it only while idle, as the block itself does not enforce this.
module key_matrix_event_encoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [kme_pkg::LIMIT_W-1:0]   cfg_data,
  input  kme_pkg::snap_t                snap,
  input  logic                          snap_valid,
  output logic                          snap_stall,
  output kme_pkg::evt_t                 evt,
  output logic                          evt_valid,
  input  logic                          evt_stall
);
  import kme_pkg::*;

  `include "key_matrix_event_encoder_macros.svh"

  logic [LIMIT_W-1:0] event_limit;
  logic               synced;

  logic               accept;
  logic               busy;
  logic [ROWS-1:0]    cols [COLUMNS];
  lane_ctl_t          ctl;
  lane_hit_t          hits [COLUMNS];
  logic [CNT_W-1:0]   counts [COLUMNS];
  logic [ROW_W-1:0]   sel_row;
  logic [LIMIT_W-1:0] change_sum;
  scan_ctx_t          ctx;

  assign snap_stall = busy;
  assign accept     = snap_valid && !snap_stall;

  always_comb begin
    cols[0] = snap.column_0[ROWS-1:0];
    cols[1] = snap.column_1[ROWS-1:0];
    cols[2] = snap.column_2[ROWS-1:0];
    cols[3] = snap.column_3[ROWS-1:0];
    cols[4] = snap.column_4[ROWS-1:0];

    ctl.clear = accept && snap.cmd == CMD_RESYNC;
    ctl.load  = accept && snap.cmd == CMD_APPLY && !synced;
    ctl.apply = accept && snap.cmd == CMD_APPLY && synced;
    ctl.sym   = cols[0][2];
    ctl.shift = cols[1][6] || cols[2][3];

    change_sum = '0;
    for (int c = 0; c < COLUMNS; c++) begin
      change_sum = change_sum + LIMIT_W'(counts[c]);
    end
    ctx.total = (change_sum > event_limit) ? event_limit : change_sum;
    ctx.sym   = ctl.sym;
    ctx.alt   = cols[0][4];
    ctx.shift = ctl.shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      event_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      synced <= 1'b0;
    end else if (ctl.load) begin
      synced <= 1'b1;
    end
  end

  for (genvar c = 0; c < COLUMNS; c++) begin : g_lane
    kme_lane #(
      .COL(c)
    ) u_lane (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .rows         (cols[c]),
      .sel_row      (sel_row),
      .hit          (hits[c]),
      .change_count (counts[c])
    );
  end

  kme_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.apply),
    .ctx       (ctx),
    .hits      (hits),
    .sel_row   (sel_row),
    .busy      (busy),
    .evt       (evt),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall)
  );

  `KME_ASSERT_NEXT(a_apply_scans, clk, rst, ctl.apply, snap_stall)
  `KME_ASSERT_NEXT(a_resync_unsyncs, clk, rst, ctl.clear, !synced)
  `KME_ASSERT_NEXT(a_load_syncs, clk, rst, ctl.load, synced && !snap_stall)
  `KME_ASSERT_NOW(a_evt_in_matrix, clk, rst, evt_valid, evt.column_index < COL_W'(COLUMNS) && evt.row_index < ROW_W'(ROWS))

endmodule
